### src/serial_commanded_dual_level_pulser_unit_macros.svh
// assertion macros for the serial commanded dual level pulser
`ifndef SERIAL_COMMANDED_DUAL_LEVEL_PULSER_UNIT_MACROS_SVH
`define SERIAL_COMMANDED_DUAL_LEVEL_PULSER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SCPDL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scpdl check failed");

// antecedent implies consequent in the next cycle
`define SCPDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scpdl check failed");

`endif

### src/scpdl_pkg.sv
// shared types and constants of the serial commanded dual level pulser
`timescale 1ns / 1ps
`default_nettype none

package scpdl_pkg;

	localparam int FRAME_LEN = 6;
	localparam int IDX_W     = $clog2(FRAME_LEN);
	localparam int LEVEL_W   = 12;
	localparam int PIN_W     = 5;
	localparam logic [7:0] CPU_RESET = 8'd16;

	localparam logic [1:0] OP_BYTE   = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_RX_ERR = 2'd2;

	localparam logic [7:0] CMD_LOAD = 8'd1;
	localparam logic [7:0] CMD_FIRE = 8'd2;

	localparam logic [1:0] ACK_NONE      = 2'd0;
	localparam logic [1:0] ACK_STORED    = 2'd1;
	localparam logic [1:0] ACK_REQUESTED = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] drive_one;
		logic [LEVEL_W-1:0] drive_two;
		logic [PIN_W-1:0]   pin_bits;
		logic               load_strobe;
		logic               ack_valid;
		logic [1:0]         ack_code;
	} out_t;

	typedef struct packed {
		logic [15:0] level_one;
		logic [15:0] level_two;
		logic [7:0]  pattern;
		logic [7:0]  pulse_len;
	} param_t;

	typedef struct packed {
		logic   pending;
		param_t params;
	} req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] drive_one;
		logic [LEVEL_W-1:0] drive_two;
		logic [PIN_W-1:0]   pin_bits;
	} drive_t;

endpackage

`default_nettype wire

### src/scpdl_parser.sv
// command byte parser, parameter frame and pending request
`timescale 1ns / 1ps
`default_nettype none

module scpdl_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire scpdl_pkg::in_t   item,
	input  wire logic             start,
	output scpdl_pkg::req_t       req,
	output logic [1:0]            ack_code
);

	logic                         collecting_q;
	logic [scpdl_pkg::IDX_W-1:0]  index_q;
	logic [7:0]                   buf_q [scpdl_pkg::FRAME_LEN-1];
	scpdl_pkg::param_t            stored_q;
	scpdl_pkg::req_t              pend_q;
	logic                         is_byte;
	logic                         last_byte;

	assign is_byte   = (item.opcode == scpdl_pkg::OP_BYTE);
	assign last_byte = (index_q == scpdl_pkg::IDX_W'(scpdl_pkg::FRAME_LEN - 1));
	assign req       = pend_q;

	always_comb begin
		ack_code = scpdl_pkg::ACK_NONE;
		if (is_byte) begin
			if (collecting_q) begin
				if (last_byte) begin
					ack_code = scpdl_pkg::ACK_STORED;
				end
			end else if (item.rx_byte == scpdl_pkg::CMD_FIRE) begin
				ack_code = scpdl_pkg::ACK_REQUESTED;
			end
		end
	end

	// frame bytes before the last one
	always_ff @(posedge clk) begin
		if (en && is_byte && collecting_q && !last_byte) begin
			buf_q[index_q] <= item.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			index_q      <= '0;
			stored_q     <= '0;
			pend_q       <= '0;
		end else if (en) begin
			if (start) begin
				pend_q.pending <= 1'b0;
			end
			case (item.opcode)
				scpdl_pkg::OP_BYTE: begin
					if (collecting_q) begin
						if (last_byte) begin
							stored_q.level_one <= {buf_q[0], buf_q[1]};
							stored_q.level_two <= {buf_q[2], buf_q[3]};
							stored_q.pattern   <= buf_q[4];
							stored_q.pulse_len <= item.rx_byte;
							collecting_q       <= 1'b0;
							index_q            <= '0;
						end else begin
							index_q <= index_q + scpdl_pkg::IDX_W'(1);
						end
					end else if (item.rx_byte == scpdl_pkg::CMD_LOAD) begin
						collecting_q <= 1'b1;
						index_q      <= '0;
					end else if (item.rx_byte == scpdl_pkg::CMD_FIRE) begin
						pend_q.params  <= stored_q;
						pend_q.pending <= 1'b1;
					end
				end
				scpdl_pkg::OP_RX_ERR: begin
					collecting_q <= 1'b0;
					index_q      <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/scpdl_pulse.sv
// pulse sequencer with tick counter and drive registers
`timescale 1ns / 1ps
`default_nettype none

module scpdl_pulse (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            tick,
	input  wire logic [7:0]      cycles_per_us,
	input  wire scpdl_pkg::req_t req,
	output logic                 start,
	output logic                 strobe,
	output scpdl_pkg::drive_t    drive_d
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [15:0]       rem_q, rem_d, rem_dec, span;
	logic [7:0]        rate;
	scpdl_pkg::drive_t drive_q;

	assign rate    = (cycles_per_us == 8'd0) ? 8'd1 : cycles_per_us;
	assign span    = 16'(req.params.pulse_len) * 16'(rate);
	assign rem_dec = (rem_q != 16'd0) ? rem_q - 16'd1 : 16'd0;

	always_comb begin
		phase_d = phase_q;
		rem_d   = rem_q;
		drive_d = drive_q;
		strobe  = 1'b0;
		start   = 1'b0;
		if (tick) begin
			case (phase_q)
				PH_IDLE: begin
					if (req.pending) begin
						start             = 1'b1;
						strobe            = 1'b1;
						drive_d.drive_one = req.params.level_one[scpdl_pkg::LEVEL_W-1:0];
						drive_d.drive_two = req.params.level_two[scpdl_pkg::LEVEL_W-1:0];
						drive_d.pin_bits  = req.params.pattern[scpdl_pkg::PIN_W-1:0];
						rem_d             = span;
						phase_d           = PH_HIGH;
					end
				end
				PH_HIGH: begin
					rem_d = rem_dec;
					if (rem_dec == 16'd0) begin
						strobe            = 1'b1;
						drive_d.drive_one = '0;
						drive_d.drive_two = '0;
						rem_d             = {8'd0, rate};
						phase_d           = PH_LOW;
					end
				end
				PH_LOW: begin
					rem_d = rem_dec;
					if (rem_dec == 16'd0) begin
						drive_d.pin_bits = '0;
						phase_d          = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rem_q   <= '0;
			drive_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			drive_q <= drive_d;
		end
	end

endmodule

`default_nettype wire

### src/serial_commanded_dual_level_pulser_unit.sv
// top level of the serial commanded dual level pulser
// an accepted transaction is registered, processed once it can advance and its
// result is held in the output register until out_ready takes it
// throughput is one transaction per cycle while out_ready stays high
// arst_n clears all control state, the levels, pins and pending request
// cycles_per_us resets to 16
`timescale 1ns / 1ps
`default_nettype none

module serial_commanded_dual_level_pulser_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic [7:0]      cfg_wr_data,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire scpdl_pkg::in_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output scpdl_pkg::out_t      out_data
);

	logic [7:0]        cycles_per_us_q;
	logic              item_vld_s1;
	scpdl_pkg::in_t    item_s1;
	logic              res_vld_s2;
	scpdl_pkg::out_t   res_s2;
	logic              advance;
	logic              start;
	logic              strobe;
	logic [1:0]        ack_code;
	scpdl_pkg::req_t   req;
	scpdl_pkg::drive_t drive_d;

	assign advance   = item_vld_s1 && (!res_vld_s2 || out_ready);
	assign in_ready  = !item_vld_s1 || advance;
	assign out_valid = res_vld_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_per_us_q <= scpdl_pkg::CPU_RESET;
		end else if (cfg_wr_en) begin
			cycles_per_us_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			res_vld_s2  <= 1'b0;
		end else begin
			if (in_ready) begin
				item_vld_s1 <= in_valid;
			end
			if (advance) begin
				res_vld_s2 <= 1'b1;
			end else if (out_ready) begin
				res_vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_s2.drive_one   <= drive_d.drive_one;
			res_s2.drive_two   <= drive_d.drive_two;
			res_s2.pin_bits    <= drive_d.pin_bits;
			res_s2.load_strobe <= strobe;
			res_s2.ack_valid   <= (ack_code != scpdl_pkg::ACK_NONE);
			res_s2.ack_code    <= ack_code;
		end
	end

	scpdl_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.item     (item_s1),
		.start    (start),
		.req      (req),
		.ack_code (ack_code)
	);

	scpdl_pulse u_pulse (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.tick          (item_s1.opcode == scpdl_pkg::OP_TICK),
		.cycles_per_us (cycles_per_us_q),
		.req           (req),
		.start         (start),
		.strobe        (strobe),
		.drive_d       (drive_d)
	);

endmodule

`default_nettype wire

### src/scpdl_checker.sv
// port level checks of the pulser top level and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "serial_commanded_dual_level_pulser_unit_macros.svh"

module scpdl_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire scpdl_pkg::out_t out_data
);

	logic out_stall;
	logic ack_agree;
	logic strobe_seen;
	logic in_take;

	assign out_stall   = out_valid && !out_ready;
	assign ack_agree   = out_data.ack_valid == (out_data.ack_code != scpdl_pkg::ACK_NONE);
	assign strobe_seen = out_valid && out_data.load_strobe;
	assign in_take     = in_valid && in_ready;

	// a stalled result transaction holds
	`SCPDL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_data))

	// ack flag and code agree
	`SCPDL_ASSERT_SAME(a_ack_code, clk, arst_n, out_valid, ack_agree)

	// a load comes from a tick and an ack from a byte, never both
	`SCPDL_ASSERT_SAME(a_strobe_ack, clk, arst_n, strobe_seen, !out_data.ack_valid)

	// no stall on the input side while the output side drains
	`SCPDL_ASSERT_SAME(a_flow, clk, arst_n, out_ready, in_ready)

	// an input transaction taken while the output is empty reaches out_valid through the item and result registers
	`SCPDL_ASSERT_NEXT(a_latency, clk, arst_n, in_take && !out_valid, ##1 out_valid)

endmodule

bind serial_commanded_dual_level_pulser_unit scpdl_checker u_scpdl_checker (.*);

`default_nettype wire

### test/testbench.sv
// self-checking testbench for the serial commanded dual level pulser unit
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 232;
	localparam int LONG_HOLD_AT = 400;
	localparam int LONG_HOLD_CYCLES = 300;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_wr_en = 1'b0;
	logic [7:0]      cfg_wr_data = '0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	scpdl_pkg::in_t  in_data = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	scpdl_pkg::out_t out_data;

	scpdl_pkg::in_t  stimulus_items[$];
	scpdl_pkg::out_t expected_outputs[$];
	scpdl_pkg::out_t oldest_expected;

	int   error_count = 0;
	int   cycle_count = 0;
	int   results_seen = 0;
	int   send_gap = 0;
	int   recv_hold = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   items_queued = 0;
	logic quiet_tail = 1'b0;
	logic long_hold_done = 1'b0;

	// predictor state
	logic [7:0]        rate_cfg = scpdl_pkg::CPU_RESET;
	logic              collecting = 1'b0;
	logic [2:0]        frame_idx = '0;
	logic [7:0]        frame_bytes [0:scpdl_pkg::FRAME_LEN-1];
	scpdl_pkg::param_t stored_params = '0;
	scpdl_pkg::req_t   queued_req = '0;
	logic [1:0]        phase = PH_IDLE;
	logic [16:0]       ticks_left = '0;
	scpdl_pkg::drive_t drive_now = '0;

	serial_commanded_dual_level_pulser_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void predict_outputs(input scpdl_pkg::in_t item);
		scpdl_pkg::out_t res;
		logic [16:0]     rate;
		rate = (rate_cfg == 8'd0) ? 17'd1 : 17'(rate_cfg);
		res = '0;
		case (item.opcode)
			scpdl_pkg::OP_BYTE: begin
				if (collecting) begin
					frame_bytes[frame_idx] = item.rx_byte;
					frame_idx = frame_idx + 3'd1;
					if (frame_idx == scpdl_pkg::FRAME_LEN) begin
						stored_params.level_one = {frame_bytes[0], frame_bytes[1]};
						stored_params.level_two = {frame_bytes[2], frame_bytes[3]};
						stored_params.pattern = frame_bytes[4];
						stored_params.pulse_len = frame_bytes[5];
						collecting = 1'b0;
						frame_idx = '0;
						res.ack_valid = 1'b1;
						res.ack_code = scpdl_pkg::ACK_STORED;
					end
				end else if (item.rx_byte == scpdl_pkg::CMD_LOAD) begin
					collecting = 1'b1;
					frame_idx = '0;
				end else if (item.rx_byte == scpdl_pkg::CMD_FIRE) begin
					queued_req.params = stored_params;
					queued_req.pending = 1'b1;
					res.ack_valid = 1'b1;
					res.ack_code = scpdl_pkg::ACK_REQUESTED;
				end
			end
			scpdl_pkg::OP_TICK: begin
				case (phase)
					PH_IDLE: begin
						if (queued_req.pending) begin
							queued_req.pending = 1'b0;
							drive_now.drive_one =
								queued_req.params.level_one[scpdl_pkg::LEVEL_W-1:0];
							drive_now.drive_two =
								queued_req.params.level_two[scpdl_pkg::LEVEL_W-1:0];
							drive_now.pin_bits =
								queued_req.params.pattern[scpdl_pkg::PIN_W-1:0];
							res.load_strobe = 1'b1;
							ticks_left = 17'(queued_req.params.pulse_len) * rate;
							phase = PH_HIGH;
						end
					end
					PH_HIGH: begin
						if (ticks_left != 0)
							ticks_left = ticks_left - 17'd1;
						if (ticks_left == 0) begin
							drive_now.drive_one = '0;
							drive_now.drive_two = '0;
							res.load_strobe = 1'b1;
							ticks_left = rate;
							phase = PH_LOW;
						end
					end
					PH_LOW: begin
						if (ticks_left != 0)
							ticks_left = ticks_left - 17'd1;
						if (ticks_left == 0) begin
							drive_now.pin_bits = '0;
							phase = PH_IDLE;
						end
					end
					default: begin
						phase = PH_IDLE;
					end
				endcase
			end
			scpdl_pkg::OP_RX_ERR: begin
				collecting = 1'b0;
				frame_idx = '0;
			end
			default: begin
			end
		endcase
		res.drive_one = drive_now.drive_one;
		res.drive_two = drive_now.drive_two;
		res.pin_bits = drive_now.pin_bits;
		expected_outputs.push_back(res);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				predict_outputs(in_data);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (stimulus_items.size() > 0) begin
					in_data <= stimulus_items.pop_front();
					in_valid <= 1'b1;
					if (!quiet_tail && $urandom_range(1, 100) <= send_idle_pct)
						send_gap = $urandom_range(1, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_outputs.size() == 0) begin
					$error("result transaction with nothing expected");
					error_count++;
				end else begin
					oldest_expected = expected_outputs.pop_front();
					if (out_data.drive_one !== oldest_expected.drive_one) begin
						$error("drive_one expected %0d got %0d",
							oldest_expected.drive_one, out_data.drive_one);
						error_count++;
					end
					if (out_data.drive_two !== oldest_expected.drive_two) begin
						$error("drive_two expected %0d got %0d",
							oldest_expected.drive_two, out_data.drive_two);
						error_count++;
					end
					if (out_data.pin_bits !== oldest_expected.pin_bits) begin
						$error("pin_bits expected %0d got %0d",
							oldest_expected.pin_bits, out_data.pin_bits);
						error_count++;
					end
					if (out_data.load_strobe !== oldest_expected.load_strobe) begin
						$error("load_strobe expected %0d got %0d",
							oldest_expected.load_strobe, out_data.load_strobe);
						error_count++;
					end
					if (out_data.ack_valid !== oldest_expected.ack_valid) begin
						$error("ack_valid expected %0d got %0d",
							oldest_expected.ack_valid, out_data.ack_valid);
						error_count++;
					end
					if (out_data.ack_code !== oldest_expected.ack_code) begin
						$error("ack_code expected %0d got %0d",
							oldest_expected.ack_code, out_data.ack_code);
						error_count++;
					end
				end
			end
			// one long hold so the block backs up into its input
			if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				recv_hold = LONG_HOLD_CYCLES;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(1, 100) <= recv_idle_pct) begin
				recv_hold = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [7:0] b);
		scpdl_pkg::in_t t;
		t.opcode = op;
		t.rx_byte = b;
		stimulus_items.push_back(t);
		items_queued++;
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_item(scpdl_pkg::OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	// command byte plus six parameter bytes, ticks may fall between bytes
	task automatic push_frame(input logic [15:0] l1, input logic [15:0] l2,
		input logic [7:0] pat, input logic [7:0] w, input logic spread);
		logic [7:0] bytes [0:5];
		bytes[0] = l1[15:8];
		bytes[1] = l1[7:0];
		bytes[2] = l2[15:8];
		bytes[3] = l2[7:0];
		bytes[4] = pat;
		bytes[5] = w;
		push_item(scpdl_pkg::OP_BYTE, scpdl_pkg::CMD_LOAD);
		for (int i = 0; i < 6; i++) begin
			if (spread && $urandom_range(0, 3) == 0)
				push_ticks($urandom_range(1, 3));
			push_item(scpdl_pkg::OP_BYTE, bytes[i]);
		end
	endtask

	task automatic queue_directed();
		push_item(scpdl_pkg::OP_BYTE, scpdl_pkg::CMD_FIRE);
		push_item(scpdl_pkg::OP_TICK, 8'h00);
		push_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 1'b0);
		push_item(scpdl_pkg::OP_BYTE, 8'h07);
		push_item(scpdl_pkg::OP_BYTE, scpdl_pkg::CMD_FIRE);
		push_item(scpdl_pkg::OP_TICK, 8'hFF);
		push_item(scpdl_pkg::OP_TICK, 8'h00);
		push_item(scpdl_pkg::OP_TICK, 8'h55);
		push_item(OP_UNUSED, 8'hAA);
		push_item(scpdl_pkg::OP_BYTE, scpdl_pkg::CMD_LOAD);
		push_item(scpdl_pkg::OP_BYTE, 8'h12);
		push_item(scpdl_pkg::OP_RX_ERR, 8'hFF);
		push_item(scpdl_pkg::OP_BYTE, 8'h34);
		push_item(scpdl_pkg::OP_TICK, 8'h00);
		push_item(scpdl_pkg::OP_TICK, 8'h00);
		push_item(scpdl_pkg::OP_BYTE, 8'h00);
		push_item(scpdl_pkg::OP_BYTE, 8'hFF);
	endtask

	task automatic queue_random_traffic(input int count);
		int          kind;
		int          w;
		int          burst;
		int          rate;
		int          target;
		rate = (rate_cfg == 8'd0) ? 1 : int'(rate_cfg);
		target = items_queued + count;
		while (items_queued < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				if (rate > 20)
					w = $urandom_range(0, 1);
				else if ($urandom_range(0, 19) == 0)
					w = $urandom_range(0, 255);
				else
					w = $urandom_range(0, 3);
				push_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)), 8'(w), 1'b1);
				if ($urandom_range(0, 3) != 0)
					push_item(scpdl_pkg::OP_BYTE, scpdl_pkg::CMD_FIRE);
				burst = rate * (w + 1) + 2;
				if (burst > 300)
					burst = 300;
				push_ticks($urandom_range(1, burst));
			end else if (kind < 52) begin
				push_item(scpdl_pkg::OP_BYTE, scpdl_pkg::CMD_FIRE);
				push_ticks($urandom_range(1, 2 * rate + 4 > 40 ? 40 : 2 * rate + 4));
			end else if (kind < 72) begin
				push_ticks($urandom_range(1, 12));
			end else if (kind < 86) begin
				push_item(scpdl_pkg::OP_BYTE, scpdl_pkg::CMD_LOAD);
				repeat ($urandom_range(0, 5))
					push_item(scpdl_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 0)
					push_item(scpdl_pkg::OP_RX_ERR, 8'($urandom_range(0, 255)));
			end else begin
				push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (stimulus_items.size() != 0 || in_valid || expected_outputs.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rate(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rate_cfg = v;
	endtask

	task automatic run_phase(input logic [7:0] v, input logic last);
		wait_drained();
		write_rate(v);
		quiet_tail = last;
		send_idle_pct = 5 * $urandom_range(0, 5);
		recv_idle_pct = 5 * $urandom_range(0, 5);
		queue_random_traffic(PHASE_ITEMS);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_rate(8'd0);
		queue_directed();
		run_phase(8'd1, 1'b0);
		run_phase(8'd2, 1'b0);
		run_phase(8'd255, 1'b0);
		run_phase(8'd3, 1'b0);
		run_phase(8'd0, 1'b0);
		run_phase(8'd16, 1'b0);
		run_phase(8'd5, 1'b0);
		run_phase(8'd1, 1'b1);
		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/scpdl_pkg.sv
src/scpdl_parser.sv
src/scpdl_pulse.sv
src/serial_commanded_dual_level_pulser_unit.sv
src/scpdl_checker.sv
test/testbench.sv
